// ===== src/pidtc_pkg.sv =====
// Shared types, constants and helpers for the trapezoidal PID core.
`default_nettype none
package pidtc_pkg;

    localparam int          MS_PER_SEC = 1000;
    // ceil(2^38 / 1000): exact quotient for any 32-bit unsigned dividend
    localparam logic [32:0] RECIP_MUL  = 33'd274877907;
    localparam int          RECIP_SH   = 38;
    localparam int          QUO_W      = 22;
    localparam int          REM_W      = 10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_MEAN,
        S_PMUL,
        S_IMUL,
        S_QMUL,
        S_QREAD,
        S_DREAD,
        S_RMUL,
        S_RREAD,
        S_INC,
        S_SUM,
        S_FIN
    } t_state;

    typedef enum logic [2:0] {
        CFG_GAIN_P = 3'd0,
        CFG_GAIN_I = 3'd1,
        CFG_GAIN_D = 3'd2,
        CFG_UPPER  = 3'd3,
        CFG_LOWER  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
    } t_mul_req;

    function automatic logic signed [31:0] clamp_bounds(
        input logic signed [49:0] x,
        input logic signed [31:0] hi,
        input logic signed [31:0] lo
    );
        logic signed [49:0] hi_w;
        logic signed [49:0] lo_w;
        hi_w = 50'(hi);
        lo_w = 50'(lo);
        if (x > hi_w) begin
            return hi;
        end else if (x < lo_w) begin
            return lo;
        end else begin
            return x[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/pidtc_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module pidtc_mul (
    input  wire logic                 i_clk,
    input  wire pidtc_pkg::t_mul_req  i_req,
    output logic signed [63:0]        o_prod
);

    logic signed [65:0] full;
    logic signed [63:0] r_prod;

    assign full = i_req.a * i_req.b;

    always_ff @(posedge i_clk) begin
        r_prod <= full[63:0];
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

// ===== src/pidtc_div.sv =====
// Divide by the millisecond-per-second constant: reciprocal quotient pick and remainder.
`default_nettype none
module pidtc_div (
    input  wire logic [63:0]                   i_prod,
    input  wire logic [31:0]                   i_mag,
    input  wire logic [pidtc_pkg::QUO_W-1:0]   i_quo,
    output logic [pidtc_pkg::QUO_W-1:0]        o_quo,
    output logic [pidtc_pkg::REM_W-1:0]        o_rem
);

    logic [31:0] quo_w;
    logic [31:0] rem_w;

    assign o_quo = i_prod[pidtc_pkg::RECIP_SH + pidtc_pkg::QUO_W - 1 : pidtc_pkg::RECIP_SH];

    // 1000 = 1024 - 16 - 8
    assign quo_w = 32'(i_quo);
    assign rem_w = i_mag - (quo_w << 10) + (quo_w << 4) + (quo_w << 3);
    assign o_rem = rem_w[pidtc_pkg::REM_W-1:0];

endmodule
`default_nettype wire

// ===== src/pid_trapezoid_clamped_core.sv =====
// Top level: sequenced PID step with trapezoidal integral and clamping.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  cfg     | i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data  | in
//  in      | i_valid o_ready i_target i_measured             | in
//          | i_measured_rate i_elapsed_ms                    |
//  out     | o_valid i_ready o_drive                         | out
//
// A transaction reaches the result register through states S_ERR to S_FIN: seven
// shared multiplier passes, two of them reciprocal multiplies for the divide by 1000.
// o_ready is high only in idle, so a new transaction waits until the last leaves S_FIN.
// Synchronous active-low reset clears gains, bounds, integral and last error.
// A result held by o_valid waits for i_ready while the next transaction is
// accepted; that one then waits in its last state until the output is taken.
`default_nettype none
module pid_trapezoid_clamped_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_target,
    input  wire logic signed [31:0] i_measured,
    input  wire logic signed [31:0] i_measured_rate,
    input  wire logic [15:0]        i_elapsed_ms,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_drive
);

    pidtc_pkg::t_state    r_state;
    pidtc_pkg::t_state    n_state;
    pidtc_pkg::t_mul_req  mul_req;

    logic signed [31:0] r_gp, r_gi, r_gd, r_upper, r_lower;
    logic signed [31:0] r_sum, r_prev;
    logic signed [31:0] r_target, r_measured, r_rate;
    logic [15:0]        r_dt;
    logic signed [31:0] r_err, r_mean, r_t;
    logic signed [47:0] r_p, r_d;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [pidtc_pkg::QUO_W-1:0] r_q;
    logic [37:0]        r_qdt;
    logic signed [39:0] r_inc;
    logic               r_out_valid;
    logic signed [31:0] r_drive;

    logic signed [63:0] prod;
    logic signed [32:0] diff;
    logic signed [32:0] pair;
    logic signed [47:0] scaled;
    logic [31:0]        abs_t;
    logic [pidtc_pkg::QUO_W-1:0] quo;
    logic [pidtc_pkg::REM_W-1:0] rem;
    logic [38:0]        inc_mag;
    logic               load_out;

    pidtc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    pidtc_div u_div (
        .i_prod (prod),
        .i_mag  (r_mag),
        .i_quo  (r_q),
        .o_quo  (quo),
        .o_rem  (rem)
    );

    assign diff     = 33'(r_target) - 33'(r_measured);
    assign pair     = 33'(r_err) + 33'(r_prev);
    assign scaled   = prod[63:16];
    assign abs_t    = r_t[31] ? 32'(-r_t) : 32'(r_t);
    assign inc_mag  = 39'(r_qdt) + 39'(quo);
    assign load_out = (r_state == pidtc_pkg::S_FIN) && (!r_out_valid || i_ready);

    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (r_state)
            pidtc_pkg::S_MEAN: begin
                mul_req.a = 33'(r_gp);
                mul_req.b = 33'(r_err);
            end
            pidtc_pkg::S_PMUL: begin
                mul_req.a = 33'(r_gi);
                mul_req.b = 33'(r_mean);
            end
            pidtc_pkg::S_QMUL: begin
                mul_req.a = {1'b0, abs_t};
                mul_req.b = pidtc_pkg::RECIP_MUL;
            end
            pidtc_pkg::S_QREAD: begin
                mul_req.a = 33'(r_gd);
                mul_req.b = 33'(r_rate);
            end
            pidtc_pkg::S_DREAD: begin
                mul_req.a = 33'(r_q);
                mul_req.b = {17'd0, r_dt};
            end
            pidtc_pkg::S_RMUL: begin
                mul_req.a = 33'(rem);
                mul_req.b = {17'd0, r_dt};
            end
            pidtc_pkg::S_RREAD: begin
                mul_req.a = 33'(prod[25:0]);
                mul_req.b = pidtc_pkg::RECIP_MUL;
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pidtc_pkg::S_IDLE:   if (i_valid) n_state = pidtc_pkg::S_ERR;
            pidtc_pkg::S_ERR:    n_state = pidtc_pkg::S_MEAN;
            pidtc_pkg::S_MEAN:   n_state = pidtc_pkg::S_PMUL;
            pidtc_pkg::S_PMUL:   n_state = pidtc_pkg::S_IMUL;
            pidtc_pkg::S_IMUL:   n_state = pidtc_pkg::S_QMUL;
            pidtc_pkg::S_QMUL:   n_state = pidtc_pkg::S_QREAD;
            pidtc_pkg::S_QREAD:  n_state = pidtc_pkg::S_DREAD;
            pidtc_pkg::S_DREAD:  n_state = pidtc_pkg::S_RMUL;
            pidtc_pkg::S_RMUL:   n_state = pidtc_pkg::S_RREAD;
            pidtc_pkg::S_RREAD:  n_state = pidtc_pkg::S_INC;
            pidtc_pkg::S_INC:    n_state = pidtc_pkg::S_SUM;
            pidtc_pkg::S_SUM:    n_state = pidtc_pkg::S_FIN;
            pidtc_pkg::S_FIN:    if (load_out) n_state = pidtc_pkg::S_IDLE;
            default:             n_state = pidtc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pidtc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp    <= '0;
            r_gi    <= '0;
            r_gd    <= '0;
            r_upper <= '0;
            r_lower <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pidtc_pkg::CFG_GAIN_P: r_gp    <= i_cfg_data;
                pidtc_pkg::CFG_GAIN_I: r_gi    <= i_cfg_data;
                pidtc_pkg::CFG_GAIN_D: r_gd    <= i_cfg_data;
                pidtc_pkg::CFG_UPPER:  r_upper <= i_cfg_data;
                pidtc_pkg::CFG_LOWER:  r_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_prev <= '0;
        end else if (r_state == pidtc_pkg::S_SUM) begin
            r_sum  <= pidtc_pkg::clamp_bounds(50'(r_sum) + 50'(r_inc), r_upper, r_lower);
            r_prev <= r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pidtc_pkg::S_IDLE && i_valid) begin
            r_target   <= i_target;
            r_measured <= i_measured;
            r_rate     <= i_measured_rate;
            r_dt       <= i_elapsed_ms;
        end
        if (r_state == pidtc_pkg::S_ERR) begin
            if (diff[32] != diff[31]) begin
                r_err <= diff[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                r_err <= diff[31:0];
            end
        end
        if (r_state == pidtc_pkg::S_MEAN) begin
            r_mean <= pair[32:1];
        end
        if (r_state == pidtc_pkg::S_PMUL) begin
            r_p <= scaled;
        end
        if (r_state == pidtc_pkg::S_IMUL) begin
            if ((&scaled[47:31]) || !(|scaled[47:31])) begin
                r_t <= scaled[31:0];
            end else begin
                r_t <= scaled[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end
        end
        if (r_state == pidtc_pkg::S_QMUL) begin
            r_mag <= abs_t;
            r_neg <= r_t[31];
        end
        if (r_state == pidtc_pkg::S_QREAD) begin
            r_q <= quo;
        end
        if (r_state == pidtc_pkg::S_DREAD) begin
            r_d <= scaled;
        end
        if (r_state == pidtc_pkg::S_RMUL) begin
            r_qdt <= prod[37:0];
        end
        if (r_state == pidtc_pkg::S_INC) begin
            r_inc <= r_neg ? -40'(inc_mag) : 40'(inc_mag);
        end
        if (load_out) begin
            r_drive <= pidtc_pkg::clamp_bounds(50'(r_p) + 50'(r_sum) - 50'(r_d),
                                               r_upper, r_lower);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == pidtc_pkg::S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_drive     = r_drive;

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pidtc_pkg::S_RMUL) |-> (rem < 10'(pidtc_pkg::MS_PER_SEC)))
        else $error("remainder out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_drive)))
        else $error("result dropped or changed while stalled");

    a_accept_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready after accepted transaction");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for pid_trapezoid_clamped_core: directed and random steps against a predictor.
`timescale 1ns / 1ps
module tb_top;

    localparam int                 Q_FRAC        = 16;
    localparam longint             MS_PER_SECOND = 1000;
    localparam longint             S32_MAX       = 64'sh0000_0000_7FFF_FFFF;
    localparam longint             S32_MIN       = -64'sh0000_0000_8000_0000;
    localparam logic signed [31:0] Q_ONE         = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX         = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN         = 32'sh8000_0000;
    localparam int                 HOLD_CYCLES   = 600;
    localparam int                 CYCLE_LIMIT   = 600_000;

    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PATTERN
    } t_sink_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_valid;
    logic               o_ready;
    logic signed [31:0] i_target;
    logic signed [31:0] i_measured;
    logic signed [31:0] i_measured_rate;
    logic [15:0]        i_elapsed_ms;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_drive;

    // predictor state
    logic signed [31:0] gain_p     = '0;
    logic signed [31:0] gain_i     = '0;
    logic signed [31:0] gain_d     = '0;
    logic signed [31:0] bound_hi   = '0;
    logic signed [31:0] bound_lo   = '0;
    logic signed [31:0] integ_acc  = '0;
    logic signed [31:0] prior_err  = '0;

    logic signed [31:0] drive_expected[$];
    logic signed [31:0] drive_want;
    int                 mismatch_count = 0;
    int                 cycle_count    = 0;
    int                 burst_left     = 0;
    bit                 hold_request   = 1'b0;

    pid_trapezoid_clamped_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_target        (i_target),
        .i_measured      (i_measured),
        .i_measured_rate (i_measured_rate),
        .i_elapsed_ms    (i_elapsed_ms),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_drive         (o_drive)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at cycle %0d, %0d results outstanding",
                     cycle_count, drive_expected.size());
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic longint sat_s32(input longint x);
        if (x > S32_MAX) return S32_MAX;
        if (x < S32_MIN) return S32_MIN;
        return x;
    endfunction

    function automatic longint to_bounds(input longint x);
        if (x > longint'(bound_hi)) return longint'(bound_hi);
        if (x < longint'(bound_lo)) return longint'(bound_lo);
        return x;
    endfunction

    function automatic void load_register(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            pidtc_pkg::CFG_GAIN_P: gain_p   = data;
            pidtc_pkg::CFG_GAIN_I: gain_i   = data;
            pidtc_pkg::CFG_GAIN_D: gain_d   = data;
            pidtc_pkg::CFG_UPPER:  bound_hi = data;
            pidtc_pkg::CFG_LOWER:  bound_lo = data;
            default: ;
        endcase
    endfunction

    // one control step: updates integral and last error, returns clamped drive
    function automatic logic signed [31:0] next_drive(input logic signed [31:0] tgt,
                                                      input logic signed [31:0] meas,
                                                      input logic signed [31:0] rate,
                                                      input logic [15:0] ms);
        longint err;
        longint avg;
        longint prop;
        longint rate_term;
        longint step_inc;
        longint deriv;
        longint total;
        err       = sat_s32(longint'(tgt) - longint'(meas));
        avg       = (err + longint'(prior_err)) >>> 1;
        prop      = (longint'(gain_p) * err) >>> Q_FRAC;
        rate_term = sat_s32((longint'(gain_i) * avg) >>> Q_FRAC);
        step_inc  = (rate_term * longint'(ms)) / MS_PER_SECOND;
        integ_acc = 32'(to_bounds(longint'(integ_acc) + step_inc));
        deriv     = (longint'(gain_d) * longint'(rate)) >>> Q_FRAC;
        total     = to_bounds(prop + longint'(integ_acc) - deriv);
        prior_err = 32'(err);
        return 32'(total);
    endfunction

    function automatic logic signed [31:0] pick_q16(input int spread);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return -32'sd1;
                endcase
            end
            default: return int'($urandom_range(0, 2 * spread)) - spread;
        endcase
    endfunction

    function automatic logic [15:0] pick_elapsed();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2, 3: return 16'($urandom);
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 30) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (drive_expected.size() == 0) begin
                report_mismatch("unexpected transaction, drive", o_drive, 'x);
            end else begin
                drive_want = drive_expected.pop_front();
                if (o_drive !== drive_want) begin
                    report_mismatch("drive", o_drive, drive_want);
                end
            end
        end
    end

    // result side: random stall patterns, plus a long hold-off on request
    initial begin : result_sink
        t_sink_mode sink_mode;
        int         mode_left;
        int         sink_tick;
        int         hold_n;
        i_ready   = 1'b0;
        sink_mode = SINK_ALWAYS;
        mode_left = 0;
        sink_tick = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                hold_n = 0;
                while (hold_n < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    hold_n++;
                end
            end
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            sink_tick++;
            case (sink_mode)
                SINK_ALWAYS: i_ready <= 1'b1;
                SINK_COIN:   i_ready <= 1'($urandom_range(0, 1));
                SINK_SPARSE: i_ready <= ($urandom_range(0, 7) == 0);
                default:     i_ready <= sink_tick[2];
            endcase
        end
    end

    task automatic send_item(input logic signed [31:0] tgt, input logic signed [31:0] meas,
                             input logic signed [31:0] rate, input logic [15:0] ms);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(0, 2);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_target        <= tgt;
        i_measured      <= meas;
        i_measured_rate <= rate;
        i_elapsed_ms    <= ms;
        do @(posedge i_clk); while (!o_ready);
        drive_expected.push_back(next_drive(tgt, meas, rate, ms));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (drive_expected.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        load_register(idx, data);
    endtask

    task automatic cfg_release();
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_loop(input logic signed [31:0] kp, input logic signed [31:0] ki,
                                input logic signed [31:0] kd, input logic signed [31:0] hi,
                                input logic signed [31:0] lo);
        drain_results();
        write_reg(pidtc_pkg::CFG_GAIN_P, kp);
        write_reg(pidtc_pkg::CFG_GAIN_I, ki);
        write_reg(pidtc_pkg::CFG_GAIN_D, kd);
        write_reg(pidtc_pkg::CFG_UPPER, hi);
        write_reg(pidtc_pkg::CFG_LOWER, lo);
        cfg_release();
    endtask

    // zero gains and bounds out of reset: drive stays at zero
    task automatic test_reset_values();
        send_item(Q_MAX, Q_MIN, Q_MAX, 16'hFFFF);
        send_item(Q_MIN, Q_MAX, Q_MIN, 16'h0000);
    endtask

    task automatic test_error_saturation();
        program_loop(Q_ONE, Q_ONE, Q_ONE, Q_MAX, Q_MIN);
        send_item(Q_MAX, Q_MIN, '0, 16'd1000);
        send_item(Q_MIN, Q_MAX, '0, 16'd1000);
        send_item(Q_ONE, '0, Q_MAX, 16'hFFFF);
        send_item('0, Q_ONE, Q_MIN, 16'd0);
        send_item(32'sh0003_8000, Q_ONE, 32'shFFFF_8000, 16'd20);
        send_item('0, '0, '0, 16'd1);
    endtask

    task automatic test_clamping();
        program_loop(Q_ONE, Q_ONE, Q_ONE, 32'sh0004_0000, 32'shFFFC_0000);
        send_item(32'sh0100_0000, '0, '0, 16'd500);
        send_item(32'shFF00_0000, '0, '0, 16'd500);
        send_item('0, '0, 32'sh0010_0000, 16'd10);
        // crossed bounds
        program_loop(Q_ONE, Q_ONE, Q_ONE, Q_MIN, Q_MAX);
        send_item('0, '0, '0, 16'd10);
        send_item(Q_ONE, '0, '0, 16'd10);
        program_loop(Q_ONE, Q_ONE, Q_ONE, -Q_ONE, Q_ONE);
        send_item('0, Q_ONE, '0, 16'd100);
        send_item(Q_ONE, '0, Q_ONE, 16'd100);
    endtask

    task automatic test_gain_extremes();
        program_loop(Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
        // unmapped indexes must not disturb anything
        for (int k = int'(pidtc_pkg::CFG_LOWER) + 1; k < 8; k++) write_reg(3'(k), $urandom);
        cfg_release();
        send_item(Q_ONE, '0, Q_ONE, 16'd1000);
        send_item(Q_MIN, Q_MAX, Q_MIN, 16'hFFFF);
        send_item(Q_MAX, Q_MIN, Q_MAX, 16'hFFFF);
        program_loop(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_item(Q_MAX, Q_MIN, Q_MIN, 16'hFFFF);
        send_item(-Q_ONE, Q_ONE, Q_MAX, 16'd1);
    endtask

    // long receiver hold-off while items keep coming, so the core stalls its input
    task automatic test_backpressure();
        program_loop(32'sh0002_0000, 32'sh0000_8000, 32'sh0000_4000,
                     32'sh0100_0000, 32'shFF00_0000);
        hold_request = 1'b1;
        burst_left = 8;
        repeat (8) send_item(pick_q16(1 << 20), pick_q16(1 << 20), pick_q16(1 << 20),
                             pick_elapsed());
    endtask

    task automatic test_random_loops();
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        logic signed [31:0] setpoint;
        logic signed [31:0] tgt;
        logic signed [31:0] meas;
        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 9))
                7: begin
                    hi = $urandom;
                    lo = $urandom;
                end
                8: begin
                    hi = Q_MAX;
                    lo = Q_MIN;
                end
                9: begin
                    hi = -int'($urandom_range(0, 1 << 20));
                    lo = int'($urandom_range(0, 1 << 20));
                end
                default: begin
                    hi = int'($urandom_range(1 << 16, 1 << 28));
                    lo = -int'($urandom_range(1 << 16, 1 << 28));
                end
            endcase
            program_loop(pick_q16(1 << 18), pick_q16(1 << 18), pick_q16(1 << 17), hi, lo);
            setpoint = pick_q16(1 << 22);
            for (int n = 0; n < 50; n++) begin
                if ($urandom_range(0, 15) == 0) setpoint = pick_q16(1 << 22);
                if ($urandom_range(0, 4) == 0) begin
                    send_item($urandom, $urandom, $urandom, 16'($urandom));
                end else begin
                    tgt  = setpoint + pick_q16(1 << 12);
                    meas = tgt - pick_q16(1 << 20);
                    send_item(tgt, meas, pick_q16(1 << 20), pick_elapsed());
                end
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_target        = '0;
        i_measured      = '0;
        i_measured_rate = '0;
        i_elapsed_ms    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_error_saturation();
        test_clamping();
        test_gain_extremes();
        test_backpressure();
        test_random_loops();

        drain_results();
        repeat (120) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/pidtc_pkg.sv
src/pidtc_mul.sv
src/pidtc_div.sv
src/pid_trapezoid_clamped_core.sv
tb/sv/tb_top.sv
